/* design/bbh_pkg.sv */
// Shared types and constants for the byte bigram histogram core.
// Used by bbh_count_bank and byte_bigram_histogram_core; depends on nothing.
package bbh_pkg;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;
    localparam int OUT_W  = 32;

    localparam logic [OP_W-1:0] OP_DATA  = 2'd0;
    localparam logic [OP_W-1:0] OP_NEW   = 2'd1;
    localparam logic [OP_W-1:0] OP_QUERY = 2'd2;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clr;
    } t_bank_ctl;

endpackage

/* design/bbh_count_bank.sv */
// Count memory with one read and one write port, same-entry bypass and saturating increment.
// Depends on bbh_pkg for the bank control struct.
module bbh_count_bank import bbh_pkg::*; #(
    parameter int DEPTH       = 256,
    parameter int COUNT_WIDTH = 32,
    localparam int ADDR_W     = $clog2(DEPTH)
) (
    input  logic                   i_clk,
    input  t_bank_ctl              i_ctl,
    input  logic [ADDR_W-1:0]      i_rd_addr,
    input  logic [ADDR_W-1:0]      i_wr_addr,
    output logic [COUNT_WIDTH-1:0] o_count,
    output logic [COUNT_WIDTH-1:0] o_count_inc
);

    logic [COUNT_WIDTH-1:0] r_mem [DEPTH];
    logic [COUNT_WIDTH-1:0] r_rd_data;
    logic [COUNT_WIDTH-1:0] r_byp_data;
    logic                   r_byp_hit;
    logic [COUNT_WIDTH-1:0] wr_data;

    assign o_count     = r_byp_hit ? r_byp_data : r_rd_data;
    assign o_count_inc = (o_count == '1) ? o_count : o_count + COUNT_WIDTH'(1);
    assign wr_data     = i_ctl.clr ? '0 : o_count_inc;

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= wr_data;
        end
    end

    // A read of the entry being written in the same cycle takes the new value.
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd_en) begin
            r_rd_data  <= r_mem[i_rd_addr];
            r_byp_hit  <= i_ctl.wr_en && (i_wr_addr == i_rd_addr);
            r_byp_data <= wr_data;
        end
    end

endmodule

/* design/byte_bigram_histogram_core.sv */
// Byte bigram histogram: pair counts, symbol counts and row flags for a byte stream.
// Each item passes a memory stage (r_s1) and an output register (r_out) to o_valid;
// one item per cycle while i_stall is low. Throughput is set by the count memories,
// read-modify-written with a one-deep bypass. After reset a clearing pass writes every
// pair, symbol and row entry with o_stall high. Depends on bbh_pkg, bbh_count_bank.
module byte_bigram_histogram_core import bbh_pkg::*; #(
    parameter int COUNT_WIDTH   = 32,
    parameter int ALPHABET_SIZE = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [OP_W-1:0]   i_op,
    input  logic [BYTE_W-1:0] i_byte_value,
    input  logic [BYTE_W-1:0] i_query_first,
    input  logic [BYTE_W-1:0] i_query_second,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [OUT_W-1:0]  o_pair_count,
    output logic [OUT_W-1:0]  o_symbol_count,
    output logic              o_row_seen,
    output logic              o_counted
);

    localparam int PAIR_DEPTH = ALPHABET_SIZE * ALPHABET_SIZE;
    localparam int PA_W       = $clog2(PAIR_DEPTH);
    localparam int SA_W       = $clog2(ALPHABET_SIZE);
    localparam logic [BYTE_W:0] ALPHA_LIM = (BYTE_W + 1)'(ALPHABET_SIZE);
    localparam logic [PA_W-1:0] PA_LAST   = PA_W'(PAIR_DEPTH - 1);
    localparam logic [PA_W-1:0] SYM_LIM   = PA_W'(ALPHABET_SIZE);

    logic                     r_clr_busy;
    logic [PA_W-1:0]          r_clr_addr;
    logic [SA_W-1:0]          r_prev;
    logic                     r_have_prev;

    logic                     r_s1_v;
    logic                     r_s1_counted;
    logic                     r_s1_pair_ok;
    logic                     r_s1_sym_ok;
    logic                     r_s1_row_ok;
    logic [PA_W-1:0]          r_s1_paddr;
    logic [SA_W-1:0]          r_s1_saddr;
    logic [SA_W-1:0]          r_s1_row;

    logic                     r_out_v;
    logic [OUT_W-1:0]         r_out_pair;
    logic [OUT_W-1:0]         r_out_sym;
    logic                     r_out_row;
    logic                     r_out_counted;

    logic                     accept;
    logic                     s1_adv;
    logic                     is_data;
    logic                     is_query;
    logic                     byte_ok;
    logic                     qf_ok;
    logic                     qs_ok;
    logic                     cnt_now;
    logic [SA_W-1:0]          first_idx;
    logic [SA_W-1:0]          second_idx;
    logic [PA_W-1:0]          pair_rd_addr;
    logic                     sym_clr;
    t_bank_ctl                pair_ctl;
    t_bank_ctl                sym_ctl;
    t_bank_ctl                row_ctl;
    logic [PA_W-1:0]          pair_wr_addr;
    logic [SA_W-1:0]          sym_wr_addr;
    logic [SA_W-1:0]          row_wr_addr;
    logic [COUNT_WIDTH-1:0]   pair_cur;
    logic [COUNT_WIDTH-1:0]   pair_inc;
    logic [COUNT_WIDTH-1:0]   sym_cur;
    logic [COUNT_WIDTH-1:0]   sym_inc;
    logic                     row_cur;
    logic                     row_inc;
    logic [OUT_W-1:0]         n_out_pair;
    logic [OUT_W-1:0]         n_out_sym;
    logic                     n_out_row;

    assign s1_adv  = r_s1_v && (!r_out_v || !i_stall);
    assign o_stall = r_clr_busy || (r_s1_v && !s1_adv);
    assign accept  = i_valid && !o_stall;

    assign is_data  = (i_op == OP_DATA);
    assign is_query = (i_op == OP_QUERY);
    assign byte_ok  = {1'b0, i_byte_value} < ALPHA_LIM;
    assign qf_ok    = {1'b0, i_query_first} < ALPHA_LIM;
    assign qs_ok    = {1'b0, i_query_second} < ALPHA_LIM;
    assign cnt_now  = is_data && byte_ok && r_have_prev;

    assign first_idx    = is_data ? r_prev : i_query_first[SA_W-1:0];
    assign second_idx   = is_data ? i_byte_value[SA_W-1:0] : i_query_second[SA_W-1:0];
    assign pair_rd_addr = PA_W'(first_idx) * PA_W'(ALPHABET_SIZE) + PA_W'(second_idx);

    assign sym_clr = r_clr_busy && (r_clr_addr < SYM_LIM);

    assign pair_ctl.rd_en = accept;
    assign pair_ctl.wr_en = r_clr_busy || (s1_adv && r_s1_counted);
    assign pair_ctl.clr   = r_clr_busy;
    assign pair_wr_addr   = r_clr_busy ? r_clr_addr : r_s1_paddr;

    assign sym_ctl.rd_en = accept;
    assign sym_ctl.wr_en = sym_clr || (s1_adv && r_s1_counted);
    assign sym_ctl.clr   = r_clr_busy;
    assign sym_wr_addr   = r_clr_busy ? r_clr_addr[SA_W-1:0] : r_s1_saddr;

    assign row_ctl.rd_en = accept;
    assign row_ctl.wr_en = sym_clr || (s1_adv && r_s1_counted);
    assign row_ctl.clr   = r_clr_busy;
    assign row_wr_addr   = r_clr_busy ? r_clr_addr[SA_W-1:0] : r_s1_row;

    bbh_count_bank #(
        .DEPTH       (PAIR_DEPTH),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_pair_bank (
        .i_clk       (i_clk),
        .i_ctl       (pair_ctl),
        .i_rd_addr   (pair_rd_addr),
        .i_wr_addr   (pair_wr_addr),
        .o_count     (pair_cur),
        .o_count_inc (pair_inc)
    );

    bbh_count_bank #(
        .DEPTH       (ALPHABET_SIZE),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_sym_bank (
        .i_clk       (i_clk),
        .i_ctl       (sym_ctl),
        .i_rd_addr   (second_idx),
        .i_wr_addr   (sym_wr_addr),
        .o_count     (sym_cur),
        .o_count_inc (sym_inc)
    );

    // A one-bit saturating count is a flag that a counted pair sets.
    bbh_count_bank #(
        .DEPTH       (ALPHABET_SIZE),
        .COUNT_WIDTH (1)
    ) u_row_bank (
        .i_clk       (i_clk),
        .i_ctl       (row_ctl),
        .i_rd_addr   (first_idx),
        .i_wr_addr   (row_wr_addr),
        .o_count     (row_cur),
        .o_count_inc (row_inc)
    );

    always_comb begin
        n_out_pair = '0;
        n_out_sym  = '0;
        n_out_row  = 1'b0;
        if (r_s1_counted) begin
            n_out_pair = OUT_W'(pair_inc);
            n_out_sym  = OUT_W'(sym_inc);
            n_out_row  = row_inc;
        end else begin
            if (r_s1_pair_ok) begin
                n_out_pair = OUT_W'(pair_cur);
            end
            if (r_s1_sym_ok) begin
                n_out_sym = OUT_W'(sym_cur);
            end
            if (r_s1_row_ok) begin
                n_out_row = row_cur;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy    <= 1'b1;
            r_clr_addr    <= '0;
            r_prev        <= '0;
            r_have_prev   <= 1'b0;
            r_s1_v        <= 1'b0;
            r_out_v       <= 1'b0;
        end else begin
            if (r_clr_busy) begin
                if (r_clr_addr == PA_LAST) begin
                    r_clr_busy <= 1'b0;
                end
                r_clr_addr <= r_clr_addr + PA_W'(1);
            end
            if (accept && is_data && byte_ok) begin
                r_prev      <= i_byte_value[SA_W-1:0];
                r_have_prev <= 1'b1;
            end else if (accept && (i_op == OP_NEW)) begin
                r_have_prev <= 1'b0;
            end
            if (accept) begin
                r_s1_v <= 1'b1;
            end else if (s1_adv) begin
                r_s1_v <= 1'b0;
            end
            if (s1_adv) begin
                r_out_v <= 1'b1;
            end else if (!i_stall) begin
                r_out_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_counted <= cnt_now;
            r_s1_pair_ok <= is_query && qf_ok && qs_ok;
            r_s1_sym_ok  <= is_query && qs_ok;
            r_s1_row_ok  <= is_query && qf_ok;
            r_s1_paddr   <= pair_rd_addr;
            r_s1_saddr   <= second_idx;
            r_s1_row     <= first_idx;
        end
        if (s1_adv) begin
            r_out_pair    <= n_out_pair;
            r_out_sym     <= n_out_sym;
            r_out_row     <= n_out_row;
            r_out_counted <= r_s1_counted;
        end
    end

    assign o_valid        = r_out_v;
    assign o_pair_count   = r_out_pair;
    assign o_symbol_count = r_out_sym;
    assign o_row_seen     = r_out_row;
    assign o_counted      = r_out_counted;

`ifndef SYNTHESIS
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_clr_busy |-> !r_s1_v && !r_out_v)
        else $error("item in flight during the clearing pass");

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_v && !s1_adv |=> r_s1_v && $stable(r_s1_paddr) && $stable(r_s1_counted))
        else $error("held item in the memory stage changed");

    a_count_decision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && cnt_now |=> r_s1_v && r_s1_counted)
        else $error("data byte with a previous byte was not marked for counting");

    a_counted_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_counted |-> o_row_seen)
        else $error("counted item without its row flag");
`endif

endmodule
